// ===== rtl/core/scan_line_planar_to_packed_macros.svh =====
// Assertion helpers for the scan line converter.
`ifndef SCAN_LINE_PLANAR_TO_PACKED_MACROS_SVH
`define SCAN_LINE_PLANAR_TO_PACKED_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define SLP2P_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scan line converter: same-cycle check failed");

// Check a condition in the cycle after its trigger.
`define SLP2P_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scan line converter: next-cycle check failed");

`endif

// ===== rtl/core/slp2p_pkg.sv =====
package slp2p_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_image;
  } in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       is_color;
    logic       end_of_row;
    logic [1:0] status;
  } out_t;

  typedef enum logic [4:0] {
    PH_WAIT  = 5'b00001,
    PH_IHDR  = 5'b00010,
    PH_RED   = 5'b00100,
    PH_GREEN = 5'b01000,
    PH_BLUE  = 5'b10000
  } phase_e;

  localparam logic [1:0] ST_PIXEL     = 2'd0;
  localparam logic [1:0] ST_BAD_TYPE  = 2'd1;
  localparam logic [1:0] ST_BAD_WIDTH = 2'd2;

  localparam logic [7:0] TYPE_D    = 8'h44;
  localparam logic [7:0] TYPE_H    = 8'h48;
  localparam logic [7:0] TYPE_L    = 8'h4C;
  localparam logic [7:0] TYPE_GRAY = 8'h40;

  localparam logic [1:0] HDR_IDLE   = 2'd0;
  localparam logic [1:0] HDR_WIDTH_LO = 2'd1;
  localparam logic [1:0] HDR_WIDTH_HI = 2'd2;
  localparam logic [1:0] HDR_DONE   = 2'd3;

endpackage

// ===== rtl/core/scan_line_planar_to_packed.sv =====
// A result is registered and appears on the output in the cycle after the byte that causes it.
// Throughput: one byte per cycle while input ready is high; a blue byte reads both line stores in that cycle.
// Input ready drops only while a result waits on the output and the sink stalls.
// Reset clears the parser and output valid; the line stores are not cleared and
// hold no defined data until written.
module scan_line_planar_to_packed #(
  parameter int unsigned MAX_LINE_WIDTH = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  slp2p_pkg::in_t    in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output slp2p_pkg::out_t   out_data_o
);

  import slp2p_pkg::*;

  localparam int unsigned IDX_W = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
  localparam int unsigned LW_W  = $clog2(MAX_LINE_WIDTH + 1);

  phase_e             phase_q, phase_d;
  logic [1:0]         hidx_q, hidx_d;
  logic [IDX_W-1:0]   bidx_q, bidx_d;
  logic [LW_W-1:0]    line_width_q, line_width_d;
  logic [7:0]         wlo_q, wlo_d;
  logic               color_q, color_d;

  logic               valid_q, valid_d;
  out_t               pix_q;
  out_t               res_d;
  logic               res_vld;
  logic [7:0]         red_rd_q, green_rd_q;

  logic               in_fire;
  logic               last;
  logic [15:0]        width_w;
  logic               wr_red, wr_green, rd_en;
  logic [7:0]         d;

  logic [7:0] red_mem   [MAX_LINE_WIDTH];
  logic [7:0] green_mem [MAX_LINE_WIDTH];

  assign in_ready_o = !valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign d          = in_data_i.data_byte;
  assign width_w    = {d, wlo_q};
  assign last       = (LW_W'(bidx_q) + LW_W'(1)) >= line_width_q;

  always_comb begin
    phase_d      = phase_q;
    hidx_d       = hidx_q;
    bidx_d       = bidx_q;
    line_width_d = line_width_q;
    wlo_d        = wlo_q;
    color_d      = color_q;
    res_vld      = 1'b0;
    res_d        = '0;
    wr_red       = 1'b0;
    wr_green     = 1'b0;
    rd_en        = 1'b0;
    if (in_fire) begin
      if (in_data_i.start_of_image) begin
        if (d == TYPE_D || d == TYPE_H || d == TYPE_L) begin
          color_d = 1'b1;
          phase_d = PH_IHDR;
          hidx_d  = HDR_WIDTH_LO;
        end else if (d == TYPE_GRAY) begin
          color_d = 1'b0;
          phase_d = PH_IHDR;
          hidx_d  = HDR_WIDTH_LO;
        end else begin
          phase_d      = PH_WAIT;
          res_vld      = 1'b1;
          res_d.status = ST_BAD_TYPE;
        end
      end else begin
        unique case (phase_q)
          PH_WAIT: begin
          end
          PH_IHDR: begin
            if (hidx_q == HDR_WIDTH_LO) begin
              wlo_d  = d;
              hidx_d = HDR_WIDTH_HI;
            end else if (width_w == 16'd0 || 32'(width_w) > MAX_LINE_WIDTH) begin
              phase_d      = PH_WAIT;
              hidx_d       = HDR_IDLE;
              res_vld      = 1'b1;
              res_d.status = ST_BAD_WIDTH;
            end else begin
              line_width_d = LW_W'(width_w);
              phase_d      = PH_RED;
              hidx_d       = HDR_DONE;
              bidx_d       = '0;
            end
          end
          PH_RED, PH_GREEN, PH_BLUE: begin
            if (hidx_q != HDR_DONE) begin
              hidx_d = hidx_q + 2'd1;
              bidx_d = '0;
            end else begin
              if (!color_q) begin
                res_vld          = 1'b1;
                res_d.red        = d;
                res_d.end_of_row = last;
                res_d.status     = ST_PIXEL;
              end else if (phase_q == PH_RED) begin
                wr_red = 1'b1;
              end else if (phase_q == PH_GREEN) begin
                wr_green = 1'b1;
              end else begin
                rd_en            = 1'b1;
                res_vld          = 1'b1;
                res_d.blue       = d;
                res_d.is_color   = 1'b1;
                res_d.end_of_row = last;
                res_d.status     = ST_PIXEL;
              end
              if (last) begin
                bidx_d = '0;
                hidx_d = HDR_IDLE;
                if (!color_q || phase_q == PH_BLUE) begin
                  phase_d = PH_RED;
                end else if (phase_q == PH_RED) begin
                  phase_d = PH_GREEN;
                end else begin
                  phase_d = PH_BLUE;
                end
              end else begin
                bidx_d = bidx_q + IDX_W'(1);
              end
            end
          end
          default: begin
            phase_d = PH_WAIT;
          end
        endcase
      end
    end
  end

  assign valid_d = res_vld || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_WAIT;
      hidx_q       <= HDR_IDLE;
      bidx_q       <= '0;
      line_width_q <= '0;
      wlo_q        <= '0;
      color_q      <= 1'b0;
      valid_q      <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      hidx_q       <= hidx_d;
      bidx_q       <= bidx_d;
      line_width_q <= line_width_d;
      wlo_q        <= wlo_d;
      color_q      <= color_d;
      valid_q      <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld) begin
      pix_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_red) begin
      red_mem[bidx_q] <= d;
    end
    if (rd_en) begin
      red_rd_q <= red_mem[bidx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_green) begin
      green_mem[bidx_q] <= d;
    end
    if (rd_en) begin
      green_rd_q <= green_mem[bidx_q];
    end
  end

  always_comb begin
    out_data_o = pix_q;
    if (pix_q.is_color) begin
      out_data_o.red   = red_rd_q;
      out_data_o.green = green_rd_q;
    end
  end

  assign out_valid_o = valid_q;

`include "scan_line_planar_to_packed_macros.svh"

  `SLP2P_ASSERT_SAME(a_read_only_color, rd_en, color_q && phase_q == PH_BLUE)
  `SLP2P_ASSERT_SAME(a_no_rw_overlap, wr_red || wr_green, !rd_en && !res_vld)
  `SLP2P_ASSERT_SAME(a_width_set, phase_q == PH_RED || phase_q == PH_GREEN || phase_q == PH_BLUE, line_width_q != '0 && LW_W'(bidx_q) < line_width_q)
  `SLP2P_ASSERT_NEXT(a_color_pix, rd_en, out_valid_o && out_data_o.is_color && out_data_o.status == ST_PIXEL)

endmodule
